// ===== rtl/obb_pkg.sv =====
// Shared constants and types for the oriented box overlap test.
`timescale 1ns / 1ps

package obb_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int NUM_EDGES       = 4;

  typedef struct packed {
    logic                 degen;
    logic [NUM_EDGES-1:0] axis_zero;
  } flags_t;

endpackage

// ===== rtl/obb_dot_stage.sv =====
// Registered products and absolute dot products of edges and center offset.
`timescale 1ns / 1ps

module obb_dot_stage #(
  parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] ex [obb_pkg::NUM_EDGES],
  input  logic signed [COORD_WIDTH-1:0] ey [obb_pkg::NUM_EDGES],
  input  logic signed [COORD_WIDTH:0]   dx,
  input  logic signed [COORD_WIDTH:0]   dy,
  output logic [2*COORD_WIDTH-1:0]      edot [obb_pkg::NUM_EDGES][obb_pkg::NUM_EDGES],
  output logic [2*COORD_WIDTH:0]        ddot [obb_pkg::NUM_EDGES]
);
  import obb_pkg::*;

  localparam int PW  = 2 * COORD_WIDTH;
  localparam int SW  = PW + 1;
  localparam int DPW = PW + 1;
  localparam int DSW = PW + 2;

  // The sign of an edge does not change the absolute value of a dot product,
  // so the up vectors are used as given.
  for (genvar i = 0; i < NUM_EDGES; i++) begin : g_row
    for (genvar j = 0; j < NUM_EDGES; j++) begin : g_col
      if (j >= i) begin : g_prod
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] neg;
        logic [PW-1:0]        mag;

        always_ff @(posedge clk) begin
          px  <= PW'(ex[i]) * PW'(ex[j]);
          py  <= PW'(ey[i]) * PW'(ey[j]);
          mag <= sum[SW-1] ? neg[PW-1:0] : sum[PW-1:0];
        end

        always_comb begin
          sum = SW'(px) + SW'(py);
          neg = -sum;
        end

        assign edot[i][j] = mag;
      end else begin : g_mirror
        assign edot[i][j] = edot[j][i];
      end
    end

    logic signed [DPW-1:0] qx;
    logic signed [DPW-1:0] qy;
    logic signed [DSW-1:0] dsum;
    logic signed [DSW-1:0] dneg;
    logic [DPW-1:0]        dmag;

    always_ff @(posedge clk) begin
      qx   <= DPW'(dx) * DPW'(ex[i]);
      qy   <= DPW'(dy) * DPW'(ey[i]);
      dmag <= dsum[DSW-1] ? dneg[DPW-1:0] : dsum[DPW-1:0];
    end

    always_comb begin
      dsum = DSW'(qx) + DSW'(qy);
      dneg = -dsum;
    end

    assign ddot[i] = dmag;
  end

endmodule

// ===== rtl/obb_axis_test.sv =====
// Projection sum and separation compare on one candidate axis.
`timescale 1ns / 1ps

module obb_axis_test #(
  parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic [2*COORD_WIDTH-1:0] edot [obb_pkg::NUM_EDGES],
  input  logic [2*COORD_WIDTH:0]   ddot,
  output logic                     sep
);
  import obb_pkg::*;

  localparam int CW = 2 * COORD_WIDTH + 2;

  logic [CW-1:0] s;
  logic [CW-1:0] t;

  always_ff @(posedge clk) begin
    s <= (CW'(edot[0]) + CW'(edot[1])) + (CW'(edot[2]) + CW'(edot[3]));
    t <= {ddot, 1'b0};
  end

  // Touching boxes, where the sums are equal, are not separated.
  assign sep = s < t;

endmodule

// ===== rtl/oriented_box_overlap_2d.sv =====
// Top level of the two-dimensional oriented box overlap test.
`timescale 1ns / 1ps

// Separating axis test for two 2D oriented boxes given as edge vectors and
// centers in signed fixed point. One box pair is taken on every clock cycle:
// busy stays low, and start is accepted whenever the block is out of reset.
// The result for a pair appears on overlap with done high for exactly one
// cycle; results come out in order and cannot be held off, so the receiver
// must take them as they come. The pipeline registers, in order, are the
// input register, a product register after each of the 28 multipliers,
// absolute dot products, per-axis sums, and the result register. overlap is
// 0 when either box has both edges zero.

module oriented_box_overlap_2d #(
  parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] a_right_x,
  input  logic signed [COORD_WIDTH-1:0] a_right_y,
  input  logic signed [COORD_WIDTH-1:0] a_up_x,
  input  logic signed [COORD_WIDTH-1:0] a_up_y,
  input  logic signed [COORD_WIDTH-1:0] b_right_x,
  input  logic signed [COORD_WIDTH-1:0] b_right_y,
  input  logic signed [COORD_WIDTH-1:0] b_up_x,
  input  logic signed [COORD_WIDTH-1:0] b_up_y,
  input  logic signed [COORD_WIDTH-1:0] a_center_x,
  input  logic signed [COORD_WIDTH-1:0] a_center_y,
  input  logic signed [COORD_WIDTH-1:0] b_center_x,
  input  logic signed [COORD_WIDTH-1:0] b_center_y,
  output logic                          done,
  output logic                          overlap
);
  import obb_pkg::*;

  logic signed [COORD_WIDTH-1:0] ex [NUM_EDGES];
  logic signed [COORD_WIDTH-1:0] ey [NUM_EDGES];
  logic signed [COORD_WIDTH:0]   dx;
  logic signed [COORD_WIDTH:0]   dy;
  logic [2*COORD_WIDTH-1:0]      edot [NUM_EDGES][NUM_EDGES];
  logic [2*COORD_WIDTH:0]        ddot [NUM_EDGES];
  logic [NUM_EDGES-1:0]          sep;
  logic [NUM_EDGES-1:0]          pass;
  logic [3:0]                    vld;
  flags_t                        flags [4];
  flags_t                        flags_next;
  logic                          a_zero;
  logic                          b_zero;

  assign busy = 1'b0;

  always_comb begin
    a_zero = (a_right_x == '0) && (a_right_y == '0) && (a_up_x == '0) && (a_up_y == '0);
    b_zero = (b_right_x == '0) && (b_right_y == '0) && (b_up_x == '0) && (b_up_y == '0);
    flags_next.degen        = a_zero || b_zero;
    flags_next.axis_zero[0] = (a_right_x == '0) && (a_right_y == '0);
    flags_next.axis_zero[1] = (a_up_x == '0) && (a_up_y == '0);
    flags_next.axis_zero[2] = (b_right_x == '0) && (b_right_y == '0);
    flags_next.axis_zero[3] = (b_up_x == '0) && (b_up_y == '0);
  end

  always_ff @(posedge clk) begin
    ex[0]    <= a_right_x;
    ey[0]    <= a_right_y;
    ex[1]    <= a_up_x;
    ey[1]    <= a_up_y;
    ex[2]    <= b_right_x;
    ey[2]    <= b_right_y;
    ex[3]    <= b_up_x;
    ey[3]    <= b_up_y;
    dx       <= (COORD_WIDTH+1)'(a_center_x) - (COORD_WIDTH+1)'(b_center_x);
    dy       <= (COORD_WIDTH+1)'(a_center_y) - (COORD_WIDTH+1)'(b_center_y);
    flags[0] <= flags_next;
    flags[1] <= flags[0];
    flags[2] <= flags[1];
    flags[3] <= flags[2];
    overlap  <= !flags[3].degen && (&pass);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[2:0], start && !busy};
      done <= vld[3];
    end
  end

  obb_dot_stage #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dot (
    .clk (clk),
    .ex  (ex),
    .ey  (ey),
    .dx  (dx),
    .dy  (dy),
    .edot(edot),
    .ddot(ddot)
  );

  for (genvar i = 0; i < NUM_EDGES; i++) begin : g_axis
    obb_axis_test #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_axis (
      .clk (clk),
      .edot(edot[i]),
      .ddot(ddot[i]),
      .sep (sep[i])
    );

    // A zero axis never separates.
    assign pass[i] = flags[3].axis_zero[i] || !sep[i];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##5 done)
    else $error("accepted beat did not produce a result five cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst) done |-> $past(start, 5))
    else $error("result strobe without a matching accepted beat");

  a_degenerate: assert property (@(posedge clk) disable iff (rst)
      done && $past(start && a_right_x == '0 && a_right_y == '0 && a_up_x == '0 &&
                    a_up_y == '0, 5) |-> !overlap)
    else $error("degenerate box A reported as overlapping");

endmodule
